### sv/mme_pkg.sv
`timescale 1ns / 1ps
package mme_pkg;

  // Input beat layout (tdata), lowest bit first
  localparam int unsigned MSG_TYPE_LSB  = 0;
  localparam int unsigned CHANNEL_LSB   = 8;
  localparam int unsigned FIRST_LSB     = 12;
  localparam int unsigned SECOND_LSB    = 20;
  localparam int unsigned WIDE_LSB      = 28;
  localparam int unsigned SYSEX_LEN_LSB = 42;
  localparam int unsigned PAYLOAD_LSB   = 58;
  localparam int unsigned SYSEX_LEN_W   = 16;
  localparam int unsigned WIDE_W        = 14;
  localparam int unsigned IN_TDATA_W    = 72;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Status codes
  localparam logic [7:0] ST_NOTE_OFF     = 8'h80;
  localparam logic [7:0] ST_NOTE_ON      = 8'h90;
  localparam logic [7:0] ST_KEY_PRESS    = 8'hA0;
  localparam logic [7:0] ST_CTRL_CHANGE  = 8'hB0;
  localparam logic [7:0] ST_PROG_CHANGE  = 8'hC0;
  localparam logic [7:0] ST_CHAN_PRESS   = 8'hD0;
  localparam logic [7:0] ST_PITCH_BEND   = 8'hE0;
  localparam logic [7:0] ST_SYSEX        = 8'hF0;
  localparam logic [7:0] ST_TIME_CODE    = 8'hF1;
  localparam logic [7:0] ST_SONG_POS     = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL     = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ     = 8'hF6;
  localparam logic [7:0] ST_SYSEX_END    = 8'hF7;
  localparam logic [7:0] ST_CLOCK        = 8'hF8;
  localparam logic [7:0] ST_START        = 8'hFA;
  localparam logic [7:0] ST_CONTINUE     = 8'hFB;
  localparam logic [7:0] ST_STOP         = 8'hFC;
  localparam logic [7:0] ST_ACTIVE_SENSE = 8'hFE;
  localparam logic [7:0] ST_SYS_RESET    = 8'hFF;
  localparam logic [7:0] ST_SYSTEM_BASE  = 8'hF0;

  // Configuration register indexes
  localparam logic CFG_UNLIMITED = 1'b0;
  localparam logic CFG_LIMIT     = 1'b1;

  typedef enum logic {
    OP_ENCODE  = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OC_BYTE     = 2'd0,
    OC_NO_ROOM  = 2'd1,
    OC_UNKNOWN  = 2'd2,
    OC_SEQUENCE = 2'd3
  } outcome_e;

  // One classified message: up to three wire bytes, index of the last one
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    outcome_e        outcome;
  } job_t;

endpackage

### sv/mme_queue.sv
`timescale 1ns / 1ps
module mme_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/mme_front.sv
`timescale 1ns / 1ps
module mme_front #(
  parameter int unsigned CAPACITY_BITS     = 16,
  parameter int unsigned SYSEX_LENGTH_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  mme_pkg::op_e                     op_i,
  input  logic [mme_pkg::IN_TDATA_W-1:0]   data_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [mme_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mme_pkg::job_t                    job_o
);

  localparam int unsigned CmpW =
    ((CAPACITY_BITS > SYSEX_LENGTH_BITS) ? CAPACITY_BITS : SYSEX_LENGTH_BITS) + 2;

  logic [7:0]                     msg_type;
  logic [3:0]                     channel;
  logic [7:0]                     first_value;
  logic [7:0]                     second_value;
  logic [mme_pkg::WIDE_W-1:0]     wide_value;
  logic [mme_pkg::SYSEX_LEN_W-1:0] sysex_length;
  logic [7:0]                     payload_byte;

  logic [SYSEX_LENGTH_BITS+mme_pkg::SYSEX_LEN_W-1:0] slen_ext;
  logic [SYSEX_LENGTH_BITS-1:0]   slen;
  logic [CAPACITY_BITS+mme_pkg::CFG_DATA_W-1:0]      limit_ext;
  logic [CAPACITY_BITS-1:0]       limit_val;

  logic                           unlimited_q, unlimited_d;
  logic [CAPACITY_BITS-1:0]       cap_q, cap_d;
  logic                           in_sysex_q, in_sysex_d;
  logic [SYSEX_LENGTH_BITS-1:0]   sysex_rem_q, sysex_rem_d;

  logic [7:0]                     status;
  logic [7:0]                     v1, v2, wide_lo, wide_hi, pay;
  logic [SYSEX_LENGTH_BITS-1:0]   rem_next;
  logic [CmpW-1:0]                need;
  logic [CmpW-1:0]                diff;
  logic                           fits;

  // Split the beat into fields
  assign msg_type     = data_i[mme_pkg::MSG_TYPE_LSB +: 8];
  assign channel      = data_i[mme_pkg::CHANNEL_LSB +: 4];
  assign first_value  = data_i[mme_pkg::FIRST_LSB +: 8];
  assign second_value = data_i[mme_pkg::SECOND_LSB +: 8];
  assign wide_value   = data_i[mme_pkg::WIDE_LSB +: mme_pkg::WIDE_W];
  assign sysex_length = data_i[mme_pkg::SYSEX_LEN_LSB +: mme_pkg::SYSEX_LEN_W];
  assign payload_byte = data_i[mme_pkg::PAYLOAD_LSB +: 8];

  // Fit length and budget to the configured counter widths
  assign slen_ext  = {{SYSEX_LENGTH_BITS{1'b0}}, sysex_length};
  assign slen      = slen_ext[SYSEX_LENGTH_BITS-1:0];
  assign limit_ext = {{CAPACITY_BITS{1'b0}}, cfg_data_i};
  assign limit_val = limit_ext[CAPACITY_BITS-1:0];

  // Data bytes carry 7 bits
  assign status  = (msg_type >= mme_pkg::ST_SYSTEM_BASE) ? msg_type
                                                          : {msg_type[7:4], channel};
  assign v1      = {1'b0, first_value[6:0]};
  assign v2      = {1'b0, second_value[6:0]};
  assign wide_lo = {1'b0, wide_value[6:0]};
  assign wide_hi = {1'b0, wide_value[13:7]};
  assign pay     = {1'b0, payload_byte[6:0]};
  assign rem_next = sysex_rem_q - SYSEX_LENGTH_BITS'(1);

  // Byte count to charge against the budget
  always_comb begin
    need = CmpW'(1);
    case (msg_type)
      mme_pkg::ST_NOTE_OFF, mme_pkg::ST_NOTE_ON, mme_pkg::ST_KEY_PRESS,
      mme_pkg::ST_CTRL_CHANGE, mme_pkg::ST_PITCH_BEND, mme_pkg::ST_SONG_POS: begin
        need = CmpW'(3);
      end
      mme_pkg::ST_PROG_CHANGE, mme_pkg::ST_CHAN_PRESS, mme_pkg::ST_TIME_CODE,
      mme_pkg::ST_SONG_SEL: begin
        need = CmpW'(2);
      end
      mme_pkg::ST_SYSEX: begin
        need = CmpW'(slen) + CmpW'(2);
      end
      default: begin
        need = CmpW'(1);
      end
    endcase
  end

  assign diff = CmpW'(cap_q) - need;
  assign fits = unlimited_q || (CmpW'(cap_q) >= need);

  // Classify the item, build its job and update sequence and budget state
  always_comb begin
    unlimited_d       = unlimited_q;
    cap_d             = cap_q;
    in_sysex_d        = in_sysex_q;
    sysex_rem_d       = sysex_rem_q;
    job_o.bytes       = '0;
    job_o.last_idx    = 2'd0;
    job_o.outcome     = mme_pkg::OC_BYTE;

    if (op_i == mme_pkg::OP_PAYLOAD) begin
      if (!in_sysex_q) begin
        job_o.outcome = mme_pkg::OC_SEQUENCE;
      end else begin
        job_o.bytes[0] = pay;
        if (accept_i) begin
          sysex_rem_d = rem_next;
        end
        if (rem_next == '0) begin
          job_o.bytes[1] = mme_pkg::ST_SYSEX_END;
          job_o.last_idx = 2'd1;
          if (accept_i) begin
            in_sysex_d = 1'b0;
          end
        end
      end
    end else if (in_sysex_q) begin
      job_o.outcome = mme_pkg::OC_SEQUENCE;
    end else begin
      job_o.bytes[0] = status;
      case (msg_type)
        mme_pkg::ST_NOTE_OFF, mme_pkg::ST_NOTE_ON, mme_pkg::ST_KEY_PRESS,
        mme_pkg::ST_CTRL_CHANGE: begin
          job_o.bytes[1] = v1;
          job_o.bytes[2] = v2;
          job_o.last_idx = 2'd2;
        end
        mme_pkg::ST_PROG_CHANGE, mme_pkg::ST_CHAN_PRESS, mme_pkg::ST_TIME_CODE,
        mme_pkg::ST_SONG_SEL: begin
          job_o.bytes[1] = v1;
          job_o.last_idx = 2'd1;
        end
        mme_pkg::ST_PITCH_BEND, mme_pkg::ST_SONG_POS: begin
          job_o.bytes[1] = wide_lo;
          job_o.bytes[2] = wide_hi;
          job_o.last_idx = 2'd2;
        end
        mme_pkg::ST_TUNE_REQ, mme_pkg::ST_CLOCK, mme_pkg::ST_START,
        mme_pkg::ST_CONTINUE, mme_pkg::ST_STOP, mme_pkg::ST_ACTIVE_SENSE,
        mme_pkg::ST_SYS_RESET: begin
          job_o.last_idx = 2'd0;
        end
        mme_pkg::ST_SYSEX: begin
          if (slen == '0) begin
            job_o.bytes[1] = mme_pkg::ST_SYSEX_END;
            job_o.last_idx = 2'd1;
          end else if (accept_i && fits) begin
            in_sysex_d  = 1'b1;
            sysex_rem_d = slen;
          end
        end
        default: begin
          job_o.bytes   = '0;
          job_o.outcome = mme_pkg::OC_UNKNOWN;
        end
      endcase

      // Reject a message that does not fit, charge one that does
      if (job_o.outcome == mme_pkg::OC_BYTE) begin
        if (!fits) begin
          job_o.bytes    = '0;
          job_o.last_idx = 2'd0;
          job_o.outcome  = mme_pkg::OC_NO_ROOM;
        end else if (accept_i && !unlimited_q) begin
          cap_d = diff[CAPACITY_BITS-1:0];
        end
      end
    end

    // Register writes set the unlimited flag or reload the budget
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mme_pkg::CFG_UNLIMITED: unlimited_d = cfg_data_i[0];
        mme_pkg::CFG_LIMIT:     cap_d       = limit_val;
        default:                unlimited_d = unlimited_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlimited_q <= 1'b1;
      cap_q       <= '0;
      in_sysex_q  <= 1'b0;
      sysex_rem_q <= '0;
    end else begin
      unlimited_q <= unlimited_d;
      cap_q       <= cap_d;
      in_sysex_q  <= in_sysex_d;
      sysex_rem_q <= sysex_rem_d;
    end
  end

endmodule

### sv/mme_back.sv
`timescale 1ns / 1ps
module mme_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mme_pkg::job_t      head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic               m_axis_tlast,
  output logic [1:0]         m_axis_tuser
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic [1:0] user_q;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = !empty_i && (!valid_q || m_axis_tready);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  // Pick the byte of the head job at the current index
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.bytes[0];
      2'd1:    sel_byte = head_i.bytes[1];
      2'd2:    sel_byte = head_i.bytes[2];
      default: sel_byte = '0;
    endcase
  end

  // Step through the job, drop the valid flag when the beat is taken
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= sel_byte;
      last_q <= is_last;
      user_q <= head_i.outcome;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = user_q;

endmodule

### sv/midi_message_encoder.sv
`timescale 1ns / 1ps
// Channel    Dir  Beat contents
// s_axis     in   tuser: operation; tdata: msg_type, channel, first_value,
//                 second_value, wide_value, sysex_length, payload_byte
// m_axis     out  tdata: out_byte; tlast: end_of_run; tuser: outcome
// cfg        in   cfg_we_i, cfg_idx_i (0 capacity_unlimited, 1 capacity_limit)
//
// The front takes one input beat per cycle while the job queue has room and
// classifies it in that cycle; the back emits one byte per cycle while
// m_axis_tready allows it, so a message leaves as 1 to 3 output bytes.
// Reset (async, active low) clears the queue, sequence state and budget.
// An output stall fills the two-entry queue, then the input stalls.
module midi_message_encoder #(
  parameter int unsigned CAPACITY_BITS     = 16,
  parameter int unsigned SYSEX_LENGTH_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // lowest bit up: msg_type[7:0], channel[11:8], first_value[19:12],
  // second_value[27:20], wide_value[41:28], sysex_length[57:42],
  // payload_byte[65:58], zero fill
  input  logic [mme_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_byte
  output logic [7:0]                       m_axis_tdata,
  output logic                             m_axis_tlast,
  // outcome
  output logic [1:0]                       m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [mme_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  mme_pkg::job_t job;
  mme_pkg::job_t head;
  logic          full, empty, pop, accept;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  mme_front #(
    .CAPACITY_BITS     (CAPACITY_BITS),
    .SYSEX_LENGTH_BITS (SYSEX_LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (mme_pkg::op_e'(s_axis_tuser)),
    .data_i     (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .job_o      (job)
  );

  mme_queue #(
    .WIDTH ($bits(mme_pkg::job_t)),
    .DEPTH (mme_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (job),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  mme_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### tb/sv/tb_midi_message_encoder.sv
`timescale 1ns / 1ps
module tb_midi_message_encoder;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;

  // Every message type the encoder knows, system exclusive excluded
  localparam logic [7:0] KNOWN_TYPES [17] = '{
    mme_pkg::ST_NOTE_OFF, mme_pkg::ST_NOTE_ON, mme_pkg::ST_KEY_PRESS,
    mme_pkg::ST_CTRL_CHANGE, mme_pkg::ST_PROG_CHANGE, mme_pkg::ST_CHAN_PRESS,
    mme_pkg::ST_PITCH_BEND, mme_pkg::ST_TIME_CODE, mme_pkg::ST_SONG_POS,
    mme_pkg::ST_SONG_SEL, mme_pkg::ST_TUNE_REQ, mme_pkg::ST_CLOCK, mme_pkg::ST_START,
    mme_pkg::ST_CONTINUE, mme_pkg::ST_STOP, mme_pkg::ST_ACTIVE_SENSE,
    mme_pkg::ST_SYS_RESET
  };

  typedef struct {
    logic [7:0]        data;
    logic              last;
    mme_pkg::outcome_e outcome;
  } wire_beat_t;

  // Tracks budget and sysex framing, holds the wire bytes still owed
  class midi_scoreboard;
    bit         unlimited = 1'b1;
    bit [15:0]  budget;
    bit         in_sysex;
    bit [15:0]  payload_left;
    wire_beat_t expected_q[$];
    int         errors, n_bytes, n_no_room, n_unknown, n_seq, n_frames;

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == mme_pkg::CFG_UNLIMITED) unlimited = val[0];
      else budget = val;
    endfunction

    function bit fits(int unsigned n);
      return unlimited || (budget >= n);
    endfunction

    // Charge the budget for a whole message, or refuse it
    function bit claim(int unsigned n);
      if (!fits(n)) return 1'b0;
      if (!unlimited) budget -= 16'(n);
      return 1'b1;
    endfunction

    function void push(logic [7:0] data, logic last, mme_pkg::outcome_e oc);
      wire_beat_t w;
      w.data = data;
      w.last = last;
      w.outcome = oc;
      expected_q.push_back(w);
      case (oc)
        mme_pkg::OC_BYTE:    n_bytes++;
        mme_pkg::OC_NO_ROOM: n_no_room++;
        mme_pkg::OC_UNKNOWN: n_unknown++;
        default:             n_seq++;
      endcase
    endfunction

    // Work out the wire bytes one accepted input beat produces
    function void note_beat(mme_pkg::op_e op, logic [mme_pkg::IN_TDATA_W-1:0] d);
      logic [7:0]  mt, v1, v2, pay;
      logic [3:0]  chan;
      logic [13:0] wide;
      logic [15:0] slen;
      logic [7:0]  msg [3];
      int unsigned n, k;
      mt   = d[mme_pkg::MSG_TYPE_LSB +: 8];
      chan = d[mme_pkg::CHANNEL_LSB +: 4];
      v1   = {1'b0, d[mme_pkg::FIRST_LSB +: 7]};
      v2   = {1'b0, d[mme_pkg::SECOND_LSB +: 7]};
      wide = d[mme_pkg::WIDE_LSB +: mme_pkg::WIDE_W];
      slen = d[mme_pkg::SYSEX_LEN_LSB +: mme_pkg::SYSEX_LEN_W];
      pay  = {1'b0, d[mme_pkg::PAYLOAD_LSB +: 7]};
      msg[1] = 8'h00;
      msg[2] = 8'h00;
      n = 0;

      if (op == mme_pkg::OP_PAYLOAD) begin
        if (!in_sysex) begin
          push(8'h00, 1'b1, mme_pkg::OC_SEQUENCE);
          return;
        end
        payload_left--;
        if (payload_left == 0) begin
          in_sysex = 1'b0;
          n_frames++;
          push(pay, 1'b0, mme_pkg::OC_BYTE);
          push(mme_pkg::ST_SYSEX_END, 1'b1, mme_pkg::OC_BYTE);
        end else begin
          push(pay, 1'b1, mme_pkg::OC_BYTE);
        end
        return;
      end

      // A new message while payload is still owed is refused as out of sequence
      if (in_sysex) begin
        push(8'h00, 1'b1, mme_pkg::OC_SEQUENCE);
        return;
      end

      msg[0] = (mt >= mme_pkg::ST_SYSTEM_BASE) ? mt : {mt[7:4], chan};
      case (mt)
        mme_pkg::ST_NOTE_OFF, mme_pkg::ST_NOTE_ON, mme_pkg::ST_KEY_PRESS,
        mme_pkg::ST_CTRL_CHANGE: begin
          n = 3;
          msg[1] = v1;
          msg[2] = v2;
        end
        mme_pkg::ST_PROG_CHANGE, mme_pkg::ST_CHAN_PRESS, mme_pkg::ST_TIME_CODE,
        mme_pkg::ST_SONG_SEL: begin
          n = 2;
          msg[1] = v1;
        end
        mme_pkg::ST_PITCH_BEND, mme_pkg::ST_SONG_POS: begin
          n = 3;
          msg[1] = {1'b0, wide[6:0]};
          msg[2] = {1'b0, wide[13:7]};
        end
        mme_pkg::ST_TUNE_REQ, mme_pkg::ST_CLOCK, mme_pkg::ST_START,
        mme_pkg::ST_CONTINUE, mme_pkg::ST_STOP, mme_pkg::ST_ACTIVE_SENSE,
        mme_pkg::ST_SYS_RESET: begin
          n = 1;
        end
        mme_pkg::ST_SYSEX: begin
          // Budget covers start byte, payload and end byte up front
          if (!claim(32'(slen) + 2)) begin
            push(8'h00, 1'b1, mme_pkg::OC_NO_ROOM);
          end else if (slen == 0) begin
            n_frames++;
            push(mme_pkg::ST_SYSEX, 1'b0, mme_pkg::OC_BYTE);
            push(mme_pkg::ST_SYSEX_END, 1'b1, mme_pkg::OC_BYTE);
          end else begin
            in_sysex = 1'b1;
            payload_left = slen;
            push(mme_pkg::ST_SYSEX, 1'b1, mme_pkg::OC_BYTE);
          end
          return;
        end
        default: begin
          push(8'h00, 1'b1, mme_pkg::OC_UNKNOWN);
          return;
        end
      endcase

      if (!claim(n)) begin
        push(8'h00, 1'b1, mme_pkg::OC_NO_ROOM);
        return;
      end
      for (k = 0; k < n; k++) push(msg[k], k == n - 1, mme_pkg::OC_BYTE);
    endfunction

    // Compare one output beat against the oldest owed byte
    function void check_beat(logic [7:0] data, logic last, logic [1:0] oc);
      wire_beat_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("%0t: unexpected output beat data %h last %b outcome %0d",
                         $time, data, last, oc));
        return;
      end
      w = expected_q.pop_front();
      if (data !== w.data || last !== w.last || oc !== w.outcome)
        report($sformatf("%0t: mismatch exp data %h last %b outcome %0d, got %h %b %0d",
                         $time, w.data, w.last, w.outcome, data, last, oc));
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [mme_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;
  logic                           m_axis_tlast;
  logic [1:0]                     m_axis_tuser;
  logic                           cfg_we_i = 1'b0;
  logic                           cfg_idx_i = 1'b0;
  logic [mme_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  midi_scoreboard sb = new();
  bit             calm = 1'b0;
  int             n_sent, n_settings;

  midi_message_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the output now and then, except during the calm stretch
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // Check every output beat as it is taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // End the run when neither side moves for too long
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Drive one input beat, with an occasional gap in front of it
  task automatic send_item(mme_pkg::op_e op, logic [7:0] mt, logic [3:0] chan,
                           logic [7:0] v1, logic [7:0] v2, logic [13:0] wide,
                           logic [15:0] slen, logic [7:0] pay);
    logic [mme_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[mme_pkg::MSG_TYPE_LSB +: 8] = mt;
    d[mme_pkg::CHANNEL_LSB +: 4] = chan;
    d[mme_pkg::FIRST_LSB +: 8] = v1;
    d[mme_pkg::SECOND_LSB +: 8] = v2;
    d[mme_pkg::WIDE_LSB +: mme_pkg::WIDE_W] = wide;
    d[mme_pkg::SYSEX_LEN_LSB +: mme_pkg::SYSEX_LEN_W] = slen;
    d[mme_pkg::PAYLOAD_LSB +: 8] = pay;
    while (!calm && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_beat(op, d);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Hold input until every owed byte is out, then let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Mostly well-formed messages and complete sysex frames, some noise
  task automatic run_random(int count);
    logic [7:0]   mt;
    logic [15:0]  slen;
    mme_pkg::op_e op;
    int           roll;
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) settle();
      roll = $urandom_range(0, 99);
      op = mme_pkg::OP_ENCODE;
      mt = KNOWN_TYPES[$urandom_range(0, 16)];
      slen = 16'($urandom_range(0, 6));
      if (sb.in_sysex) begin
        if (roll < 85) begin
          op = mme_pkg::OP_PAYLOAD;
        end else if (roll < 92) begin
          op = mme_pkg::op_e'($urandom_range(0, 1));
          mt = 8'($urandom_range(0, 255));
        end
      end else if (roll < 8) begin
        op = mme_pkg::op_e'($urandom_range(0, 1));
        mt = 8'($urandom_range(0, 255));
        slen = 16'($urandom_range(0, 65535));
      end else if (roll < 30) begin
        mt = mme_pkg::ST_SYSEX;
        if ($urandom_range(0, 3) == 0) slen = 16'($urandom_range(0, 65535));
      end
      // Long lengths only where the budget turns them away
      if (mt == mme_pkg::ST_SYSEX && slen > 8 && sb.fits(32'(slen) + 2))
        slen = 16'($urandom_range(0, 8));
      send_item(op, mt, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)), slen,
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(bit unl, logic [15:0] lim, int count);
    settle();
    write_reg(mme_pkg::CFG_UNLIMITED, {15'b0, unl});
    write_reg(mme_pkg::CFG_LIMIT, lim);
    n_settings++;
    run_random(count);
  endtask

  initial begin : stimulus
    int i;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every known type, fields alternating between their extremes
    for (i = 0; i < 17; i++) begin
      send_item(mme_pkg::OP_ENCODE, KNOWN_TYPES[i], i[0] ? 4'hF : 4'h0,
                i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF,
                i[0] ? 14'h3FFF : 14'h0000, 16'h0000, 8'h00);
    end
    // Channel type with a nonzero low nibble, and the bare end byte
    send_item(mme_pkg::OP_ENCODE, 8'h85, 4'h3, 8'h12, 8'h34, 14'h0, 16'h0, 8'h00);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_SYSEX_END, 4'h0, 8'h00, 8'h00, 14'h0,
              16'h0, 8'h00);
    // Payload with no frame open, empty frame, then a two-byte frame
    // interrupted by a message
    send_item(mme_pkg::OP_PAYLOAD, 8'h00, 4'h0, 8'h00, 8'h00, 14'h0, 16'h0, 8'h55);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_SYSEX, 4'h0, 8'h00, 8'h00, 14'h0,
              16'h0000, 8'h00);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_SYSEX, 4'h0, 8'h00, 8'h00, 14'h0,
              16'h0002, 8'h00);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_NOTE_ON, 4'h1, 8'h40, 8'h40, 14'h0,
              16'h0, 8'h00);
    send_item(mme_pkg::OP_PAYLOAD, 8'h00, 4'h0, 8'h00, 8'h00, 14'h0, 16'h0, 8'hFF);
    send_item(mme_pkg::OP_PAYLOAD, 8'h00, 4'h0, 8'h00, 8'h00, 14'h0, 16'h0, 8'h00);

    // Empty budget refuses everything, the longest frame included
    settle();
    write_reg(mme_pkg::CFG_UNLIMITED, 16'h0000);
    write_reg(mme_pkg::CFG_LIMIT, 16'h0000);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_NOTE_ON, 4'h2, 8'h3C, 8'h7F, 14'h0,
              16'h0, 8'h00);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_SYSEX, 4'h0, 8'h00, 8'h00, 14'h0,
              16'hFFFF, 8'h00);
    // Budget of four: one note fits, a program change then does not
    settle();
    write_reg(mme_pkg::CFG_LIMIT, 16'd4);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_NOTE_ON, 4'h2, 8'h3C, 8'h7F, 14'h0,
              16'h0, 8'h00);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_PROG_CHANGE, 4'h2, 8'h05, 8'h00, 14'h0,
              16'h0, 8'h00);
    send_item(mme_pkg::OP_ENCODE, mme_pkg::ST_CLOCK, 4'h0, 8'h00, 8'h00, 14'h0,
              16'h0, 8'h00);

    run_phase(1'b1, 16'hFFFF, 50);
    run_phase(1'b0, 16'hFFFF, 50);
    run_phase(1'b0, 16'($urandom_range(20, 120)), 50);
    run_phase(1'b0, 16'h0000, 20);
    calm = 1'b1;
    run_phase(1'b1, 16'h0000, 50);
    calm = 1'b0;
    run_phase(1'b0, 16'($urandom_range(1, 16)), 40);
    settle();

    $display("Sent %0d input beats over %0d budget settings; %0d wire bytes, %0d sysex frames",
             n_sent, n_settings + 2, sb.n_bytes, sb.n_frames);
    $display("Refusals seen: %0d no room, %0d unknown type, %0d out of sequence",
             sb.n_no_room, sb.n_unknown, sb.n_seq);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("mismatches: %0d, bytes still owed: %0d", sb.errors, sb.expected_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mme_pkg.sv
sv/mme_queue.sv
sv/mme_front.sv
sv/mme_back.sv
sv/midi_message_encoder.sv
tb/sv/tb_midi_message_encoder.sv
